>>> rtl/b64u_pkg.sv
package b64u_pkg;

    localparam int JOBQ_DEPTH = 2;

    localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;
    localparam logic [1:0] LAST_IDX_FOUR  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out_item;

    // one group of up to 24 bits, oldest byte in the top bits
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  last_idx;   // index of the final character of the group
        logic        eom;
    } t_job;

    function automatic logic [6:0] sextet_to_char(input logic [5:0] s);
        logic [6:0] c;
        c = 7'd0;
        case (s) inside
            [6'd0:6'd25]:  c = 7'(s) + 7'd65;
            [6'd26:6'd51]: c = 7'(s) + 7'd71;
            [6'd52:6'd61]: c = 7'(s) - 7'd4;
            6'd62:         c = 7'd45;
            default:       c = 7'd95;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/base64url_encoder_no_padding.sv
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------
// input    | in        | push / full           | i_in_item  (data_byte, eom flag)
// result   | out       | empty / pop           | o_out_item (out_char, last_char)
//
// One byte may be taken every cycle while the job queue has room; each group
// of three bytes (or a final partial group) becomes one job of two to four
// characters. The back end emits one character per cycle while the result
// side keeps popping, so that one-character output stage sets the sustained
// rate on full groups. Reset clears pending bytes, the job queue and the
// output slot. A stalled result side fills the job queue and then raises full.
module base64url_encoder_no_padding #(
    parameter int JOBQ_DEPTH = b64u_pkg::JOBQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  b64u_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output b64u_pkg::t_out_item o_out_item
);

    logic           w_job_push, w_job_pop, w_job_empty;
    b64u_pkg::t_job w_job_in, w_job_out;

    b64u_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_in_item  (i_in_item),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    b64u_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .i_pop   (w_job_pop),
        .o_empty (w_job_empty),
        .o_full  (full),
        .o_job   (w_job_out)
    );

    b64u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/b64u_front.sv
module b64u_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  b64u_pkg::t_in_item i_in_item,
    output logic              o_job_push,
    output b64u_pkg::t_job    o_job
);

    logic [15:0] r_pend_bits, n_pend_bits;
    logic [1:0]  r_pend_cnt,  n_pend_cnt;
    logic [7:0]  w_byte;
    logic        w_eom;

    assign w_byte = i_in_item.data_byte;
    assign w_eom  = i_in_item.end_of_message;

    always_comb begin
        n_pend_bits  = r_pend_bits;
        n_pend_cnt   = r_pend_cnt;
        o_job_push   = 1'b0;
        o_job.group  = {8'h00, 16'h0000};
        o_job.last_idx = b64u_pkg::LAST_IDX_FOUR;
        o_job.eom    = w_eom;
        case (r_pend_cnt)
            2'd2: begin
                o_job.group    = {r_pend_bits, w_byte};
                o_job.last_idx = b64u_pkg::LAST_IDX_FOUR;
                o_job_push     = i_accept;
                if (i_accept) begin
                    n_pend_bits = 16'h0000;
                    n_pend_cnt  = 2'd0;
                end
            end
            2'd1: begin
                o_job.group    = {r_pend_bits[7:0], w_byte, 8'h00};
                o_job.last_idx = b64u_pkg::LAST_IDX_THREE;
                o_job_push     = i_accept && w_eom;
                if (i_accept) begin
                    n_pend_bits = w_eom ? 16'h0000 : {r_pend_bits[7:0], w_byte};
                    n_pend_cnt  = w_eom ? 2'd0 : 2'd2;
                end
            end
            default: begin
                // a count of three never arises; it behaves as empty
                o_job.group    = {w_byte, 16'h0000};
                o_job.last_idx = b64u_pkg::LAST_IDX_TWO;
                o_job_push     = i_accept && w_eom;
                if (i_accept) begin
                    n_pend_bits = w_eom ? 16'h0000 : {8'h00, w_byte};
                    n_pend_cnt  = w_eom ? 2'd0 : 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= 16'h0000;
            r_pend_cnt  <= 2'd0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

endmodule

>>> rtl/b64u_jobq.sv
module b64u_jobq #(
    parameter int DEPTH = b64u_pkg::JOBQ_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64u_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_full,
    output b64u_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64u_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_cnt;
    logic           w_do_push, w_do_pop;

    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == FULL_CNT);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> rtl/b64u_back.sv
module b64u_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    input  b64u_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output b64u_pkg::t_out_item o_out_item
);

    logic [1:0]          r_char_idx;
    logic                r_valid;
    b64u_pkg::t_out_item r_out;
    logic                w_load;
    logic [5:0]          w_sextet;
    logic                w_final;

    assign o_empty    = !r_valid;
    assign o_out_item = r_out;
    // output slot refills in the same cycle its content transfers out, if a job is waiting
    assign w_load     = !i_job_empty && (!r_valid || i_pop);
    assign w_final    = (r_char_idx == i_job.last_idx);
    assign o_job_pop  = w_load && w_final;

    always_comb begin
        case (r_char_idx)
            2'd0:    w_sextet = i_job.group[23:18];
            2'd1:    w_sextet = i_job.group[17:12];
            2'd2:    w_sextet = i_job.group[11:6];
            default: w_sextet = i_job.group[5:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_char  <= b64u_pkg::sextet_to_char(w_sextet);
            r_out.last_char <= w_final && i_job.eom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_char_idx <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid    <= 1'b1;
                r_char_idx <= w_final ? 2'd0 : r_char_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
